/* hdl/ttaw_pkg.sv */
// Package for the ANSI text terminal writer: field widths, default screen
// geometry, escape parser phase type, control byte codes and SGR color lookup.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ttaw_pkg;

   // Field and state widths
   localparam int CHAR_W  = 8;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int ADDR_W  = 11;
   localparam int VALUE_W = 16;
   localparam int ATTR_W  = 8;
   localparam int NUM_W   = 8;

   // Default screen geometry
   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   // Attribute after reset: white on black
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

   // Byte codes the parser reacts to
   localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;
   localparam logic [CHAR_W-1:0] CH_ESC    = 8'h1B;
   localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
   localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
   localparam logic [CHAR_W-1:0] CH_SGR    = 8'h6D;
   localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

   // Saturation limit of the escape parameter
   localparam int NUM_MAX = 255;

   // SGR codes
   localparam logic [NUM_W-1:0] SGR_CODE_DEFAULT = 8'd0;
   localparam logic [NUM_W-1:0] SGR_CODE_RED     = 8'd31;
   localparam logic [NUM_W-1:0] SGR_CODE_GREEN   = 8'd32;
   localparam logic [NUM_W-1:0] SGR_CODE_YELLOW  = 8'd33;
   localparam logic [NUM_W-1:0] SGR_CODE_BLUE    = 8'd34;
   localparam logic [NUM_W-1:0] SGR_CODE_MAGENTA = 8'd35;
   localparam logic [NUM_W-1:0] SGR_CODE_CYAN    = 8'd36;
   localparam logic [NUM_W-1:0] SGR_CODE_GRAY    = 8'd37;

   // Attribute bytes selected by the SGR codes
   localparam logic [ATTR_W-1:0] ATTR_FG_WHITE   = 8'h0F;
   localparam logic [ATTR_W-1:0] ATTR_FG_RED     = 8'h0C;
   localparam logic [ATTR_W-1:0] ATTR_FG_GREEN   = 8'h0A;
   localparam logic [ATTR_W-1:0] ATTR_FG_YELLOW  = 8'h0E;
   localparam logic [ATTR_W-1:0] ATTR_FG_BLUE    = 8'h09;
   localparam logic [ATTR_W-1:0] ATTR_FG_MAGENTA = 8'h0D;
   localparam logic [ATTR_W-1:0] ATTR_FG_CYAN    = 8'h0B;
   localparam logic [ATTR_W-1:0] ATTR_FG_GRAY    = 8'h07;

   // Escape parser phase; the unused code behaves as plain text
   typedef enum logic [1:0] {
      PH_TEXT = 2'd0,
      PH_ESC  = 2'd1,
      PH_CSI  = 2'd2
   } phase_type;

   // SGR code to attribute byte; unknown codes keep the current attribute
   function automatic logic [ATTR_W-1:0] sgr_attr(input logic [NUM_W-1:0] code,
                                                  input logic [ATTR_W-1:0] current);
      logic [ATTR_W-1:0] attr;
      case (code)
         SGR_CODE_DEFAULT: attr = ATTR_FG_WHITE;
         SGR_CODE_RED:     attr = ATTR_FG_RED;
         SGR_CODE_GREEN:   attr = ATTR_FG_GREEN;
         SGR_CODE_YELLOW:  attr = ATTR_FG_YELLOW;
         SGR_CODE_BLUE:    attr = ATTR_FG_BLUE;
         SGR_CODE_MAGENTA: attr = ATTR_FG_MAGENTA;
         SGR_CODE_CYAN:    attr = ATTR_FG_CYAN;
         SGR_CODE_GRAY:    attr = ATTR_FG_GRAY;
         default:          attr = current;
      endcase
      return attr;
   endfunction

endpackage

`default_nettype wire

/* hdl/text_terminal_ansi_writer_top.sv */
// Each accepted request beat gives its response beat in the cycle after it.
// Throughput: one byte per cycle; a new byte is taken while a response waits
// as long as that response leaves the output register in the same cycle.
// The cursor, parser and color update is one combinational pass into the
// output register. Synchronous active-high reset clears cursor, parser
// phase and parameter, sets the attribute to white on black, empties output.
// Top level of the ANSI text terminal writer.
// Depends on ttaw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module text_terminal_ansi_writer_top #(
   parameter int COLUMNS = ttaw_pkg::DEF_COLUMNS,
   parameter int ROWS    = ttaw_pkg::DEF_ROWS
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire  [ttaw_pkg::CHAR_W-1:0]      req_char_byte,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic                             rsp_cell_write,
   output logic [ttaw_pkg::ADDR_W-1:0]      rsp_cell_addr,
   output logic [ttaw_pkg::VALUE_W-1:0]     rsp_cell_value,
   output logic                             rsp_scroll_up,
   output logic                             rsp_cursor_update,
   output logic [ttaw_pkg::ADDR_W-1:0]      rsp_cursor_addr
);

   localparam int COL_W  = ttaw_pkg::COL_W;
   localparam int ROW_W  = ttaw_pkg::ROW_W;
   localparam int ADDR_W = ttaw_pkg::ADDR_W;
   localparam int LIN_W  = COL_W + ROW_W;
   localparam int NUM_W  = ttaw_pkg::NUM_W;
   localparam int ATTR_W = ttaw_pkg::ATTR_W;
   localparam int PROD_W = NUM_W + 4;

   // State registers
   ttaw_pkg::phase_type       phase_ff, phase_in;
   logic [NUM_W-1:0]          num_ff, num_in;
   logic [ATTR_W-1:0]         attr_ff, attr_in;
   logic [COL_W-1:0]          col_ff, col_in;
   logic [ROW_W-1:0]          row_ff, row_in;

   // Output register
   logic                          valid_ff;
   logic                          cell_write_ff, cell_write_in;
   logic [ADDR_W-1:0]             cell_addr_ff, cell_addr_in;
   logic [ttaw_pkg::VALUE_W-1:0]  cell_value_ff, cell_value_in;
   logic                          scroll_ff, scroll_in;
   logic                          cur_upd_ff, cur_upd_in;
   logic [ADDR_W-1:0]             cur_addr_ff, cur_addr_in;

   // Working values of the cursor update
   logic [COL_W:0]            col_work;
   logic [ROW_W:0]            row_work;
   logic [LIN_W-1:0]          cell_lin;
   logic [LIN_W-1:0]          cur_lin;
   logic [PROD_W-1:0]         num_acc;
   logic                      accept;

   assign req_ready = !valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Linear address of the cell under the cursor before the step
   assign cell_lin = LIN_W'(row_ff) * LIN_W'(COLUMNS) + LIN_W'(col_ff);

   // Parameter accumulate: value * 10 + digit, saturated below
   assign num_acc = PROD_W'(num_ff) * PROD_W'(10)
                  + PROD_W'(req_char_byte - ttaw_pkg::CH_ZERO);

   // Next state and result of one byte
   always_comb begin
      phase_in      = phase_ff;
      num_in        = num_ff;
      attr_in       = attr_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      cell_write_in = 1'b0;
      cell_addr_in  = '0;
      cell_value_in = '0;
      scroll_in     = 1'b0;
      cur_upd_in    = 1'b0;
      cur_addr_in   = '0;
      col_work      = {1'b0, col_ff};
      row_work      = {1'b0, row_ff};
      cur_lin       = '0;
      unique case (phase_ff)
         ttaw_pkg::PH_ESC: begin
            if (req_char_byte == ttaw_pkg::CH_LBRACK) begin
               phase_in = ttaw_pkg::PH_CSI;
               num_in   = '0;
            end else begin
               phase_in = ttaw_pkg::PH_TEXT;
            end
         end
         ttaw_pkg::PH_CSI: begin
            if (req_char_byte >= ttaw_pkg::CH_ZERO && req_char_byte <= ttaw_pkg::CH_NINE) begin
               num_in = (num_acc > PROD_W'(ttaw_pkg::NUM_MAX)) ? NUM_W'(ttaw_pkg::NUM_MAX)
                                                               : num_acc[NUM_W-1:0];
            end else if (req_char_byte == ttaw_pkg::CH_SEMI) begin
               num_in = '0;
            end else begin
               if (req_char_byte == ttaw_pkg::CH_SGR) begin
                  attr_in = ttaw_pkg::sgr_attr(num_ff, attr_ff);
               end
               phase_in = ttaw_pkg::PH_TEXT;
               num_in   = '0;
            end
         end
         default: begin
            if (req_char_byte == ttaw_pkg::CH_ESC) begin
               phase_in = ttaw_pkg::PH_ESC;
            end else begin
               phase_in = ttaw_pkg::PH_TEXT;
               // cursor movement or cell write
               if (req_char_byte == ttaw_pkg::CH_LF) begin
                  col_work = '0;
                  row_work = row_work + 1'b1;
               end else if (req_char_byte == ttaw_pkg::CH_BS) begin
                  if (col_ff != '0) begin
                     col_work = col_work - 1'b1;
                  end else if (row_ff != '0) begin
                     row_work = row_work - 1'b1;
                     col_work = (COL_W + 1)'(COLUMNS - 1);
                  end
               end else if (req_char_byte == ttaw_pkg::CH_CR) begin
                  col_work = '0;
               end else begin
                  cell_write_in = 1'b1;
                  cell_addr_in  = cell_lin[ADDR_W-1:0];
                  cell_value_in = {attr_ff, req_char_byte};
                  col_work      = col_work + 1'b1;
                  if (col_work >= (COL_W + 1)'(COLUMNS)) begin
                     col_work = '0;
                     row_work = row_work + 1'b1;
                  end
               end
               // past the last row: scroll and hold on the last row
               if (row_work >= (ROW_W + 1)'(ROWS)) begin
                  scroll_in = 1'b1;
                  row_work  = (ROW_W + 1)'(ROWS - 1);
               end
               col_in      = col_work[COL_W-1:0];
               row_in      = row_work[ROW_W-1:0];
               cur_lin     = LIN_W'(row_in) * LIN_W'(COLUMNS) + LIN_W'(col_in);
               cur_upd_in  = 1'b1;
               cur_addr_in = cur_lin[ADDR_W-1:0];
            end
         end
      endcase
   end

   // Parser, attribute and cursor state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ttaw_pkg::PH_TEXT;
         num_ff   <= '0;
         attr_ff  <= ttaw_pkg::ATTR_RESET;
         col_ff   <= '0;
         row_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         num_ff   <= num_in;
         attr_ff  <= attr_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   // Response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         cell_write_ff <= cell_write_in;
         cell_addr_ff  <= cell_addr_in;
         cell_value_ff <= cell_value_in;
         scroll_ff     <= scroll_in;
         cur_upd_ff    <= cur_upd_in;
         cur_addr_ff   <= cur_addr_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_cell_write    = cell_write_ff;
   assign rsp_cell_addr     = cell_addr_ff;
   assign rsp_cell_value    = cell_value_ff;
   assign rsp_scroll_up     = scroll_ff;
   assign rsp_cursor_update = cur_upd_ff;
   assign rsp_cursor_addr   = cur_addr_ff;

endmodule

`default_nettype wire

/* hdl/ttaw_checker.sv */
// Port-level checker for the ANSI text terminal writer, bound to the top.
// Depends on text_terminal_ansi_writer_top and ttaw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttaw_assertions (
   input wire                           clock,
   input wire                           reset,
   input wire                           req_ready,
   input wire                           rsp_valid,
   input wire                           rsp_ready,
   input wire                           rsp_cell_write,
   input wire [ttaw_pkg::ADDR_W-1:0]    rsp_cell_addr,
   input wire [ttaw_pkg::VALUE_W-1:0]   rsp_cell_value,
   input wire                           rsp_scroll_up,
   input wire                           rsp_cursor_update,
   input wire [ttaw_pkg::ADDR_W-1:0]    rsp_cursor_addr
);

   // No response right after reset
   a_empty_after_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response beat stays valid with its cell value and cursor address held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_value)
                                  && $stable(rsp_cursor_addr))
      else $error("stalled response changed");

   // Request ready exactly when output register is free or draining
   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow output register");

   // Escape bytes give an all-zero beat; cell writes and scrolls load the cursor
   a_cursor_with_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_cursor_update |-> !rsp_cell_write && !rsp_scroll_up
                                         && rsp_cursor_addr == '0)
      else $error("side effect without cursor update");

   // No cell fields without a cell write
   a_cell_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_cell_write |-> rsp_cell_addr == '0 && rsp_cell_value == '0)
      else $error("cell fields set without cell write");

endmodule

bind text_terminal_ansi_writer_top ttaw_assertions u_ttaw_assertions (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_cell_write    (rsp_cell_write),
   .rsp_cell_addr     (rsp_cell_addr),
   .rsp_cell_value    (rsp_cell_value),
   .rsp_scroll_up     (rsp_scroll_up),
   .rsp_cursor_update (rsp_cursor_update),
   .rsp_cursor_addr   (rsp_cursor_addr)
);

`default_nettype wire
